// ===== rtl/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotor substitution stepper package
// Shared types, command codes and modulo-26 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    localparam int unsigned LETTERS = 26;
    localparam int unsigned LTR_W   = 5;

    typedef logic [LTR_W-1:0] letter_t;

    typedef enum logic [1:0] {
        CMD_FORWARD = 2'd0,
        CMD_REVERSE = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_SET     = 2'd3
    } rss_cmd_t;

    localparam logic [2:0] REG_WIRING_LOW  = 3'd0;
    localparam logic [2:0] REG_WIRING_MID  = 3'd1;
    localparam logic [2:0] REG_WIRING_HIGH = 3'd2;
    localparam logic [2:0] REG_NOTCH_MASK  = 3'd3;
    localparam logic [2:0] REG_RING_OFFSET = 3'd4;

    typedef struct packed {
        logic [59:0] wiring_low;
        logic [59:0] wiring_mid;
        logic [9:0]  wiring_high;
        logic [25:0] notch_mask;
        logic [4:0]  ring_offset;
    } rss_cfg_t;

    // Classified transaction passed from front to back
    typedef struct packed {
        rss_cmd_t cmd;
        letter_t  entry;
        letter_t  shift;
        logic     carry;
        letter_t  position;
    } rss_item_t;

    function automatic letter_t mod26(input letter_t v);
        mod26 = (v >= letter_t'(LETTERS)) ? letter_t'(v - letter_t'(LETTERS)) : v;
    endfunction

    function automatic letter_t add_mod26(input letter_t a, input letter_t b);
        logic [LTR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (LTR_W+1)'(LETTERS)) begin
            sum = sum - (LTR_W+1)'(LETTERS);
        end
        add_mod26 = sum[LTR_W-1:0];
    endfunction

    function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
        if (a >= b) begin
            sub_mod26 = letter_t'(a - b);
        end else begin
            sub_mod26 = letter_t'(a + letter_t'(LETTERS) - b);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rotor_substitution_stepper_unit.sv =====
// ----------------------------------------------------------------------------
// Rotor substitution stepper unit
// One cipher-machine rotor: forward/reverse substitution, stepping, loading.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: s_tuser carries cmd (forward, reverse, step, set),
//   s_tdata carries letter_in and new_position. Master stream m_*: one
//   transaction per command with letter_out, carry and current_position.
//   APB port programs wiring (three words), notch mask and ring setting at
//   byte addresses 0, 8, 16, 24, 32; write only while the unit is idle.
//   An accepted input reaches m_tvalid through the queue, then the
//   registered substitution stage. Throughput: one transaction per cycle
//   while the receiver accepts, set by the position update in the front end.
//   The front end keeps the rotor position and fills a QUEUE_DEPTH-entry
//   queue; when the receiver stalls the output register holds and the queue
//   fills, after which s_tready drops. Reset clears position, registers and
//   queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rotor_substitution_stepper_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // letter_in[4:0], new_position[9:5]
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // letter_out[4:0], carry[5], current_position[10:6]
);
    import rss_pkg::*;

    rss_cfg_t   cfg_reg;
    rss_item_t  fr_item, q_item;
    logic       q_push, q_pop, q_full, q_empty;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIRING_LOW:  cfg_reg.wiring_low  <= pwdata[59:0];
                REG_WIRING_MID:  cfg_reg.wiring_mid  <= pwdata[59:0];
                REG_WIRING_HIGH: cfg_reg.wiring_high <= pwdata[9:0];
                REG_NOTCH_MASK:  cfg_reg.notch_mask  <= pwdata[25:0];
                REG_RING_OFFSET: cfg_reg.ring_offset <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIRING_LOW:  prdata = {4'd0, cfg_reg.wiring_low};
            REG_WIRING_MID:  prdata = {4'd0, cfg_reg.wiring_mid};
            REG_WIRING_HIGH: prdata = {54'd0, cfg_reg.wiring_high};
            REG_NOTCH_MASK:  prdata = {38'd0, cfg_reg.notch_mask};
            REG_RING_OFFSET: prdata = {59'd0, cfg_reg.ring_offset};
            default:         prdata = '0;
        endcase
    end

    rss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (fr_item)
    );

    rss_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (fr_item),
        .pop     (q_pop),
        .rd_item (q_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    rss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/rss_front.sv =====
// ----------------------------------------------------------------------------
// Rotor front end
// Accepts commands, keeps the rotor position and classifies each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rss_pkg::rss_cfg_t cfg,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // letter_in[4:0], new_position[9:5]
    input  wire logic [1:0]        s_tuser,   // cmd[1:0]
    input  wire logic              q_full,
    output logic                   q_push,
    output rss_pkg::rss_item_t     q_item
);
    import rss_pkg::*;

    letter_t  position_reg, position_next;
    letter_t  letter, new_pos, ring, shift;
    rss_cmd_t cmd;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        cmd     = rss_cmd_t'(s_tuser);
        letter  = mod26(s_tdata[4:0]);
        new_pos = mod26(s_tdata[9:5]);
        ring    = mod26(cfg.ring_offset);
        shift   = sub_mod26(position_reg, ring);

        position_next  = position_reg;
        q_item.cmd     = cmd;
        q_item.entry   = add_mod26(letter, shift);
        q_item.shift   = shift;
        q_item.carry   = 1'b0;
        case (cmd)
            CMD_STEP: begin
                q_item.carry  = cfg.notch_mask[position_reg];
                position_next = (position_reg == letter_t'(LETTERS - 1)) ? '0
                              : letter_t'(position_reg + 1'b1);
            end
            CMD_SET: begin
                position_next = new_pos;
            end
            default: begin
            end
        endcase
        q_item.position = position_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
        end else if (q_push) begin
            position_reg <= position_next;
        end
    end

`ifndef SYNTHESIS
    ast_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg < letter_t'(LETTERS))
        else $error("rotor position out of range");
    ast_hold_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_push |=> $stable(position_reg))
        else $error("position changed without a transaction");
    ast_carry_step: assert property (@(posedge aclk) disable iff (!aresetn)
        q_item.carry |-> (q_item.cmd == CMD_STEP))
        else $error("carry on a non-step command");
`endif

endmodule

`default_nettype wire

// ===== rtl/rss_fifo.sv =====
// ----------------------------------------------------------------------------
// Rotor command queue
// Small register FIFO decoupling the front end from the substitution stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire rss_pkg::rss_item_t wr_item,
    input  wire logic               pop,
    output rss_pkg::rss_item_t      rd_item,
    output logic                    full,
    output logic                    empty
);
    import rss_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rss_item_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                            : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                            : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

`ifndef SYNTHESIS
    ast_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    ast_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");
    ast_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/rss_back.sv =====
// ----------------------------------------------------------------------------
// Rotor substitution stage
// Forward lookup or inverse search through the wiring, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rss_pkg::rss_cfg_t  cfg,
    input  wire logic               q_empty,
    input  wire rss_pkg::rss_item_t q_item,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata    // letter_out[4:0], carry[5],
                                               // current_position[10:6]
);
    import rss_pkg::*;

    letter_t wiring [LETTERS];
    letter_t fwd_target, inv_target, target, letter_out;
    logic    valid_reg;
    logic [15:0] data_reg, data_next;

    always_comb begin
        for (int i = 0; i < 12; i++) begin
            wiring[i]      = cfg.wiring_low[5*i +: 5];
            wiring[i + 12] = cfg.wiring_mid[5*i +: 5];
        end
        wiring[24] = cfg.wiring_high[4:0];
        wiring[25] = cfg.wiring_high[9:5];
    end

    always_comb begin
        inv_target = q_item.entry;
        for (int i = 0; i < LETTERS; i++) begin
            if (wiring[i] == q_item.entry) begin
                inv_target = letter_t'(i);
            end
        end
        fwd_target = mod26(wiring[q_item.entry]);
        target     = (q_item.cmd == CMD_REVERSE) ? inv_target : fwd_target;
        letter_out = '0;
        if (q_item.cmd == CMD_FORWARD || q_item.cmd == CMD_REVERSE) begin
            letter_out = sub_mod26(target, q_item.shift);
        end
        data_next = {5'd0, q_item.position, q_item.carry, letter_out};
    end

    assign q_pop    = !q_empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTHESIS
    ast_letter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg[4:0] < letter_t'(LETTERS)))
        else $error("letter_out out of range");
    ast_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg[10:6] < letter_t'(LETTERS)))
        else $error("current_position out of range");
    ast_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> valid_reg)
        else $error("popped transaction not presented");
`endif

endmodule

`default_nettype wire
